### sv/lts_pkg.sv
// Package for the Lox token scanner: token codes, scan modes, result item type.
// No dependencies.
package lts_pkg;
  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_BANG    = 4'd3;
  localparam logic [3:0] M_EQUAL   = 4'd4;
  localparam logic [3:0] M_LESS    = 4'd5;
  localparam logic [3:0] M_GREATER = 4'd6;
  localparam logic [3:0] M_IDENT   = 4'd7;
  localparam logic [3:0] M_NUMBER  = 4'd8;
  localparam logic [3:0] M_NUMDOT  = 4'd9;
  localparam logic [3:0] M_FRAC    = 4'd10;
  localparam logic [3:0] M_STRING  = 4'd11;

  localparam logic [5:0] T_LPAREN  = 6'd0;
  localparam logic [5:0] T_RPAREN  = 6'd1;
  localparam logic [5:0] T_LBRACE  = 6'd2;
  localparam logic [5:0] T_RBRACE  = 6'd3;
  localparam logic [5:0] T_COMMA   = 6'd4;
  localparam logic [5:0] T_DOT     = 6'd5;
  localparam logic [5:0] T_MINUS   = 6'd6;
  localparam logic [5:0] T_PLUS    = 6'd7;
  localparam logic [5:0] T_SEMI    = 6'd8;
  localparam logic [5:0] T_SLASH   = 6'd9;
  localparam logic [5:0] T_STAR    = 6'd10;
  localparam logic [5:0] T_BANG    = 6'd11;
  localparam logic [5:0] T_BANG_EQ = 6'd12;
  localparam logic [5:0] T_EQUAL   = 6'd13;
  localparam logic [5:0] T_EQ_EQ   = 6'd14;
  localparam logic [5:0] T_GREATER = 6'd15;
  localparam logic [5:0] T_GT_EQ   = 6'd16;
  localparam logic [5:0] T_LESS    = 6'd17;
  localparam logic [5:0] T_LT_EQ   = 6'd18;
  localparam logic [5:0] T_IDENT   = 6'd19;
  localparam logic [5:0] T_STRING  = 6'd20;
  localparam logic [5:0] T_NUMBER  = 6'd21;
  localparam logic [5:0] T_AND     = 6'd22;
  localparam logic [5:0] T_CLASS   = 6'd23;
  localparam logic [5:0] T_ELSE    = 6'd24;
  localparam logic [5:0] T_FALSE   = 6'd25;
  localparam logic [5:0] T_FOR     = 6'd26;
  localparam logic [5:0] T_FUN     = 6'd27;
  localparam logic [5:0] T_IF      = 6'd28;
  localparam logic [5:0] T_NIL     = 6'd29;
  localparam logic [5:0] T_OR      = 6'd30;
  localparam logic [5:0] T_PRINT   = 6'd31;
  localparam logic [5:0] T_RETURN  = 6'd32;
  localparam logic [5:0] T_SUPER   = 6'd33;
  localparam logic [5:0] T_THIS    = 6'd34;
  localparam logic [5:0] T_TRUE    = 6'd35;
  localparam logic [5:0] T_VAR     = 6'd36;
  localparam logic [5:0] T_WHILE   = 6'd37;
  localparam logic [5:0] T_ERROR   = 6'd38;
  localparam logic [5:0] T_EOF     = 6'd39;

  localparam logic [1:0] E_NONE       = 2'd0;
  localparam logic [1:0] E_UNEXPECTED = 2'd1;
  localparam logic [1:0] E_UNTERM     = 2'd2;

  typedef struct packed {
    logic [5:0]             tok_code;
    logic [1:0]             error_code;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   line_number;
  } tok_t;

  // Keyword lookup from the stored prefix (first six bytes, first byte lowest).
  function automatic logic [5:0] kw_code(input logic [47:0] pfx,
                                         input logic [OFFSET_BITS-1:0] len);
    logic [5:0] code;
    code = T_IDENT;
    unique case (len)
      OFFSET_BITS'(2): begin
        if (pfx[15:0] == 16'h6669) code = T_IF;
        else if (pfx[15:0] == 16'h726f) code = T_OR;
      end
      OFFSET_BITS'(3): begin
        unique case (pfx[23:0])
          24'h646e61: code = T_AND;
          24'h726f66: code = T_FOR;
          24'h6e7566: code = T_FUN;
          24'h6c696e: code = T_NIL;
          24'h726176: code = T_VAR;
          default: code = T_IDENT;
        endcase
      end
      OFFSET_BITS'(4): begin
        unique case (pfx[31:0])
          32'h65736c65: code = T_ELSE;
          32'h73696874: code = T_THIS;
          32'h65757274: code = T_TRUE;
          default: code = T_IDENT;
        endcase
      end
      OFFSET_BITS'(5): begin
        unique case (pfx[39:0])
          40'h7373616c63: code = T_CLASS;
          40'h65736c6166: code = T_FALSE;
          40'h746e697270: code = T_PRINT;
          40'h7265707573: code = T_SUPER;
          40'h656c696877: code = T_WHILE;
          default: code = T_IDENT;
        endcase
      end
      OFFSET_BITS'(6): begin
        if (pfx == 48'h6e7275746572) code = T_RETURN;
      end
      default: code = T_IDENT;
    endcase
    return code;
  endfunction
endpackage

### sv/lox_token_scanner_unit.sv
// Lox token scanner top level: one byte per item in, up to three tokens out.
// A byte's first token is valid in the cycle after it is taken. One byte per
// cycle while the receiver is ready and each byte gives at most one token;
// more tokens hold the input until they drain. Results sit in a three-entry
// output buffer; a byte is taken when the buffer is empty or drains this
// cycle. Synchronous active-low reset: idle, offset 0, line 1. Uses lts_pkg.
module lox_token_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_value[7:0]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // tok_code, error_code, start_offset, token_length,
                                  // line_number, zero pad
  output logic        out_tlast
);
  localparam int OB = lts_pkg::OFFSET_BITS;
  localparam int LB = lts_pkg::LINE_BITS;
  localparam logic [OB-1:0] OMAX = '1;
  localparam logic [LB-1:0] LMAX = '1;
  localparam logic [5:0]    NO_TOK = 6'd63;

  logic [3:0]    mode_r, mode_nxt;
  logic [OB-1:0] start_r, start_nxt, pos_r, pos_nxt;
  logic [LB-1:0] line_r, line_nxt;
  logic [47:0]   pfx_r, pfx_nxt;
  logic          eof_r, eof_nxt;

  lts_pkg::tok_t buf_r [3];
  lts_pkg::tok_t tk    [3];
  logic [1:0]    cnt_r, cnt_nxt, rd_r, rd_nxt;
  logic [1:0]    n;

  logic take, drained;
  assign drained   = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign in_tready = drained;
  assign take      = in_tvalid && in_tready;

  // Build one result item.
  function automatic lts_pkg::tok_t mk(input logic [5:0] t, input logic [1:0] e,
                                       input logic [OB-1:0] s, input logic [OB-1:0] l,
                                       input logic [LB-1:0] ln);
    lts_pkg::tok_t r;
    r.tok_code = t; r.error_code = e; r.start_offset = s;
    r.token_length = l; r.line_number = ln;
    return r;
  endfunction

  function automatic logic [OB-1:0] ssub(input logic [OB-1:0] a, input logic [OB-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  always_comb begin
    logic [7:0]    c;
    logic          rescan, closing;
    logic [OB-1:0] len, dot;
    logic [5:0]    st;
    c = in_tdata;
    mode_nxt = mode_r; start_nxt = start_r; pos_nxt = pos_r; line_nxt = line_r;
    pfx_nxt = pfx_r; eof_nxt = eof_r;
    n = 2'd0; rescan = 1'b0; closing = 1'b0;
    st = NO_TOK;
    tk[0] = mk('0, lts_pkg::E_NONE, '0, '0, '0); tk[1] = tk[0]; tk[2] = tk[0];
    len = ssub(pos_r, start_r);
    dot = ssub(pos_r, OB'(1));
    if (take && !eof_r) begin
      if (in_tuser || c == 8'd0) begin
        closing = 1'b1;
        eof_nxt = 1'b1;
      end else begin
        unique case (mode_r)
          lts_pkg::M_IDLE: rescan = 1'b1;
          lts_pkg::M_SLASH:
            if (c == 8'h2f) mode_nxt = lts_pkg::M_COMMENT;
            else closing = 1'b1;
          lts_pkg::M_COMMENT:
            if (c == 8'h0a) begin mode_nxt = lts_pkg::M_IDLE; rescan = 1'b1; end
          lts_pkg::M_BANG, lts_pkg::M_EQUAL, lts_pkg::M_LESS, lts_pkg::M_GREATER:
            if (c == 8'h3d) begin
              unique case (mode_r)
                lts_pkg::M_BANG:  st = lts_pkg::T_BANG_EQ;
                lts_pkg::M_EQUAL: st = lts_pkg::T_EQ_EQ;
                lts_pkg::M_GREATER: st = lts_pkg::T_GT_EQ;
                default: st = lts_pkg::T_LT_EQ;
              endcase
              tk[0] = mk(st, lts_pkg::E_NONE, start_r, OB'(2), line_r);
              n = 2'd1; mode_nxt = lts_pkg::M_IDLE;
            end else closing = 1'b1;
          lts_pkg::M_IDENT:
            if (alpha(c) || digit(c)) begin
              if (len < OB'(6)) pfx_nxt = pfx_r | (48'(c) << {len[2:0], 3'b000});
            end else closing = 1'b1;
          lts_pkg::M_NUMBER:
            if (c == 8'h2e) mode_nxt = lts_pkg::M_NUMDOT;
            else if (!digit(c)) closing = 1'b1;
          lts_pkg::M_NUMDOT:
            if (digit(c)) mode_nxt = lts_pkg::M_FRAC;
            else closing = 1'b1;
          lts_pkg::M_FRAC:
            if (!digit(c)) closing = 1'b1;
          lts_pkg::M_STRING:
            if (c == 8'h22) begin
              // Hold the length at all ones once it has saturated.
              tk[0] = mk(lts_pkg::T_STRING, lts_pkg::E_NONE, start_r,
                         (len == OMAX) ? len : len + OB'(1), line_r);
              n = 2'd1; mode_nxt = lts_pkg::M_IDLE;
            end else if (c == 8'h0a && line_r != LMAX) line_nxt = line_r + LB'(1);
          default: begin mode_nxt = lts_pkg::M_IDLE; rescan = 1'b1; end
        endcase
        if (closing) rescan = 1'b1;
        if (pos_r != OMAX) pos_nxt = pos_r + OB'(1);
      end
      // Close the pending token.
      if (closing) begin
        mode_nxt = lts_pkg::M_IDLE;
        unique case (mode_r)
          lts_pkg::M_SLASH: begin
            tk[0] = mk(lts_pkg::T_SLASH, lts_pkg::E_NONE, start_r, OB'(1), line_r);
            n = 2'd1;
          end
          lts_pkg::M_BANG: begin
            tk[0] = mk(lts_pkg::T_BANG, lts_pkg::E_NONE, start_r, OB'(1), line_r);
            n = 2'd1;
          end
          lts_pkg::M_EQUAL: begin
            tk[0] = mk(lts_pkg::T_EQUAL, lts_pkg::E_NONE, start_r, OB'(1), line_r);
            n = 2'd1;
          end
          lts_pkg::M_GREATER: begin
            tk[0] = mk(lts_pkg::T_GREATER, lts_pkg::E_NONE, start_r, OB'(1), line_r);
            n = 2'd1;
          end
          lts_pkg::M_LESS: begin
            tk[0] = mk(lts_pkg::T_LESS, lts_pkg::E_NONE, start_r, OB'(1), line_r);
            n = 2'd1;
          end
          lts_pkg::M_IDENT: begin
            tk[0] = mk(lts_pkg::kw_code(pfx_r, len), lts_pkg::E_NONE, start_r, len, line_r);
            n = 2'd1;
          end
          lts_pkg::M_NUMBER, lts_pkg::M_FRAC: begin
            tk[0] = mk(lts_pkg::T_NUMBER, lts_pkg::E_NONE, start_r, len, line_r); n = 2'd1;
          end
          lts_pkg::M_NUMDOT: begin
            tk[0] = mk(lts_pkg::T_NUMBER, lts_pkg::E_NONE, start_r, ssub(dot, start_r),
                       line_r);
            tk[1] = mk(lts_pkg::T_DOT, lts_pkg::E_NONE, dot, OB'(1), line_r);
            n = 2'd2;
          end
          lts_pkg::M_STRING: begin
            tk[0] = mk(lts_pkg::T_ERROR, lts_pkg::E_UNTERM, start_r, len, line_r); n = 2'd1;
          end
          default: n = 2'd0;
        endcase
      end
      if (eof_nxt) begin
        tk[n] = mk(lts_pkg::T_EOF, lts_pkg::E_NONE, pos_r, '0, line_r);
        n = n + 2'd1;
      end else if (rescan) begin
        // Scan the byte afresh from idle.
        st = NO_TOK;
        unique case (c)
          8'h20, 8'h0d, 8'h09: st = NO_TOK;
          8'h0a: if (line_r != LMAX) line_nxt = line_r + LB'(1);
          8'h28: st = lts_pkg::T_LPAREN;
          8'h29: st = lts_pkg::T_RPAREN;
          8'h7b: st = lts_pkg::T_LBRACE;
          8'h7d: st = lts_pkg::T_RBRACE;
          8'h2c: st = lts_pkg::T_COMMA;
          8'h2e: st = lts_pkg::T_DOT;
          8'h2d: st = lts_pkg::T_MINUS;
          8'h2b: st = lts_pkg::T_PLUS;
          8'h3b: st = lts_pkg::T_SEMI;
          8'h2a: st = lts_pkg::T_STAR;
          8'h2f: begin mode_nxt = lts_pkg::M_SLASH; start_nxt = pos_r; end
          8'h21: begin mode_nxt = lts_pkg::M_BANG; start_nxt = pos_r; end
          8'h3d: begin mode_nxt = lts_pkg::M_EQUAL; start_nxt = pos_r; end
          8'h3c: begin mode_nxt = lts_pkg::M_LESS; start_nxt = pos_r; end
          8'h3e: begin mode_nxt = lts_pkg::M_GREATER; start_nxt = pos_r; end
          8'h22: begin mode_nxt = lts_pkg::M_STRING; start_nxt = pos_r; end
          default:
            if (alpha(c)) begin
              mode_nxt = lts_pkg::M_IDENT; start_nxt = pos_r; pfx_nxt = 48'(c);
            end else if (digit(c)) begin
              mode_nxt = lts_pkg::M_NUMBER; start_nxt = pos_r;
            end else st = lts_pkg::T_ERROR;
        endcase
        if (st != NO_TOK) begin
          tk[n] = mk(st, (st == lts_pkg::T_ERROR) ? lts_pkg::E_UNEXPECTED : lts_pkg::E_NONE,
                     pos_r, OB'(1), line_nxt);
          n = n + 2'd1;
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (cnt_r != 2'd0 && out_tready) begin
      cnt_nxt = cnt_r - 2'd1;
      rd_nxt  = rd_r + 2'd1;
    end
    if (take) begin
      cnt_nxt = n;
      rd_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lts_pkg::M_IDLE;
      start_r <= '0;
      pos_r <= '0;
      line_r <= LB'(1);
      pfx_r <= '0;
      eof_r <= 1'b0;
      cnt_r <= 2'd0;
      rd_r <= 2'd0;
    end else begin
      mode_r <= mode_nxt;
      start_r <= start_nxt;
      pos_r <= pos_nxt;
      line_r <= line_nxt;
      pfx_r <= pfx_nxt;
      eof_r <= eof_nxt;
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf_r[0] <= tk[0];
      buf_r[1] <= tk[1];
      buf_r[2] <= tk[2];
    end
  end

  lts_pkg::tok_t cur;
  assign cur        = (rd_r == 2'd0) ? buf_r[0] : (rd_r == 2'd1) ? buf_r[1] : buf_r[2];
  assign out_tvalid = cnt_r != 2'd0;
  assign out_tlast  = cnt_r == 2'd1;
  assign out_tdata  = {2'b00, cur.line_number, cur.token_length, cur.start_offset,
                       cur.error_code, cur.tok_code};
endmodule

### bench/tb.sv
// Testbench for lox_token_scanner_unit: drives a source byte stream and checks
// every token against a behavioural scanner kept alongside. Depends on lts_pkg.
`timescale 1ns / 100ps

module tb;
  import lts_pkg::*;

  typedef struct packed {
    logic [5:0]  ttype;
    logic [1:0]  err;
    logic [23:0] start;
    logic [23:0] len;
    logic [19:0] line;
    logic        last;
  } token_t;

  localparam int OFF_MAX   = (1 << OFFSET_BITS) - 1;
  localparam int LINE_MAX  = (1 << LINE_BITS) - 1;
  localparam int CYCLE_CAP = 200000;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        out_tlast;

  lox_token_scanner_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // scanner state
  logic [3:0]  mode;
  logic [23:0] tok_start;
  logic [23:0] pos;
  logic [19:0] lines;
  logic [47:0] prefix;
  logic        eof_done;

  token_t expected_tokens[$];
  int     errors;
  int     tx_idle;
  int     rx_idle;
  int     rx_hold;
  int     cycles;

  string kw_words[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                          "or", "print", "return", "super", "this", "true", "var", "while"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [23:0] sub_floor(logic [23:0] a, logic [23:0] b);
    return (a > b) ? a - b : 24'd0;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_token(logic [5:0] t, logic [1:0] e, logic [23:0] s,
                                    logic [23:0] l);
    token_t tk;
    tk.ttype = t;
    tk.err   = e;
    tk.start = s;
    tk.len   = l;
    tk.line  = lines;
    tk.last  = 1'b0;
    expected_tokens.push_back(tk);
  endfunction

  function automatic void next_line();
    if (lines < LINE_MAX) lines++;
  endfunction

  function automatic logic [5:0] word_code(logic [23:0] l);
    bit same;
    for (int k = 0; k < 16; k++) begin
      if (l != kw_words[k].len()) continue;
      same = 1;
      for (int i = 0; i < kw_words[k].len(); i++)
        if (prefix[8*i +: 8] != kw_words[k][i]) same = 0;
      if (same) return T_NUMBER + 6'(k + 1);
    end
    return T_IDENT;
  endfunction

  function automatic void close_token(logic [23:0] p);
    logic [3:0]  m;
    logic [23:0] dot;
    m = mode;
    mode = M_IDLE;
    case (m)
      M_SLASH:   add_token(T_SLASH, E_NONE, tok_start, 1);
      M_BANG:    add_token(T_BANG, E_NONE, tok_start, 1);
      M_EQUAL:   add_token(T_EQUAL, E_NONE, tok_start, 1);
      M_GREATER: add_token(T_GREATER, E_NONE, tok_start, 1);
      M_LESS:    add_token(T_LESS, E_NONE, tok_start, 1);
      M_IDENT:   add_token(word_code(sub_floor(p, tok_start)), E_NONE, tok_start,
                           sub_floor(p, tok_start));
      M_NUMBER, M_FRAC: add_token(T_NUMBER, E_NONE, tok_start, sub_floor(p, tok_start));
      M_NUMDOT: begin
        dot = sub_floor(p, 1);
        add_token(T_NUMBER, E_NONE, tok_start, sub_floor(dot, tok_start));
        add_token(T_DOT, E_NONE, dot, 1);
      end
      M_STRING:  add_token(T_ERROR, E_UNTERM, tok_start, sub_floor(p, tok_start));
      default: ;
    endcase
  endfunction

  function automatic void open_token(logic [7:0] c, logic [23:0] p);
    case (c)
      " ", "\r", "\t": ;
      "\n": next_line();
      "(": add_token(T_LPAREN, E_NONE, p, 1);
      ")": add_token(T_RPAREN, E_NONE, p, 1);
      "{": add_token(T_LBRACE, E_NONE, p, 1);
      "}": add_token(T_RBRACE, E_NONE, p, 1);
      ",": add_token(T_COMMA, E_NONE, p, 1);
      ".": add_token(T_DOT, E_NONE, p, 1);
      "-": add_token(T_MINUS, E_NONE, p, 1);
      "+": add_token(T_PLUS, E_NONE, p, 1);
      ";": add_token(T_SEMI, E_NONE, p, 1);
      "*": add_token(T_STAR, E_NONE, p, 1);
      "/": begin mode = M_SLASH; tok_start = p; end
      "!": begin mode = M_BANG; tok_start = p; end
      "=": begin mode = M_EQUAL; tok_start = p; end
      "<": begin mode = M_LESS; tok_start = p; end
      ">": begin mode = M_GREATER; tok_start = p; end
      "\"": begin mode = M_STRING; tok_start = p; end
      default: begin
        if (is_alpha(c)) begin
          mode = M_IDENT;
          tok_start = p;
          prefix = {40'd0, c};
        end else if (is_digit(c)) begin
          mode = M_NUMBER;
          tok_start = p;
        end else begin
          add_token(T_ERROR, E_UNEXPECTED, p, 1);
        end
      end
    endcase
  endfunction

  // Returns 1 when the byte is consumed, 0 when it must be scanned again.
  function automatic bit scan_byte(logic [7:0] c, logic [23:0] p);
    logic [23:0] idx;
    case (mode)
      M_IDLE: begin open_token(c, p); return 1; end
      M_SLASH: if (c == "/") begin mode = M_COMMENT; return 1; end
      M_COMMENT: begin
        if (c == "\n") begin mode = M_IDLE; return 0; end
        return 1;
      end
      M_BANG, M_EQUAL, M_LESS, M_GREATER:
        if (c == "=") begin
          add_token(mode == M_BANG ? T_BANG_EQ : mode == M_EQUAL ? T_EQ_EQ :
                    mode == M_GREATER ? T_GT_EQ : T_LT_EQ, E_NONE, tok_start, 2);
          mode = M_IDLE;
          return 1;
        end
      M_IDENT:
        if (is_alpha(c) || is_digit(c)) begin
          idx = sub_floor(p, tok_start);
          if (idx < 6) prefix[8*idx +: 8] = c;
          return 1;
        end
      M_NUMBER: begin
        if (is_digit(c)) return 1;
        if (c == ".") begin mode = M_NUMDOT; return 1; end
      end
      M_NUMDOT: if (is_digit(c)) begin mode = M_FRAC; return 1; end
      M_FRAC: if (is_digit(c)) return 1;
      M_STRING: begin
        if (c == "\"") begin
          idx = sub_floor(p, tok_start);
          add_token(T_STRING, E_NONE, tok_start, (idx == 24'hFFFFFF) ? idx : idx + 24'd1);
          mode = M_IDLE;
        end else if (c == "\n") begin
          next_line();
        end
        return 1;
      end
      default: begin mode = M_IDLE; return 0; end
    endcase
    close_token(p);
    return 0;
  endfunction

  function automatic void predict_tokens(logic kind, logic [7:0] c);
    int     before_n;
    token_t tk;
    before_n = expected_tokens.size();
    if (eof_done) return;
    if (kind == KIND_END || c == 8'd0) begin
      close_token(pos);
      add_token(T_EOF, E_NONE, pos, 0);
      eof_done = 1'b1;
    end else begin
      while (!scan_byte(c, pos)) ;
      if (pos < OFF_MAX) pos++;
    end
    if (expected_tokens.size() > before_n) begin
      tk = expected_tokens.pop_back();
      tk.last = 1'b1;
      expected_tokens.push_back(tk);
    end
  endfunction

  task automatic send_item(logic kind, logic [7:0] c);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= c;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    predict_tokens(kind, c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_BYTE, s[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic string random_fragment();
    string s;
    int    n;
    case ($urandom_range(13))
      0, 1: s = kw_words[$urandom_range(15)];
      2, 3: begin
        n = $urandom_range(1, 9);
        s = "";
        for (int i = 0; i < n; i++)
          s = {s, string'(byte'(i == 0 ? "a" + $urandom_range(25) :
                                ($urandom_range(1) ? "0" + $urandom_range(9) :
                                                     "A" + $urandom_range(25))))};
      end
      4: s = $sformatf("%0d", $urandom_range(99999));
      5: s = $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(99));
      6: s = $sformatf("%0d.x", $urandom_range(99));
      7: s = $urandom_range(1) ? "\"str ing\"" : "\"a\nb\"";
      8: begin
        string ops[18] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*", "/",
                           "!", "!=", "=", "==", "<", "<=", ">="};
        s = ops[$urandom_range(17)];
      end
      9: s = "// note\n";
      10: s = "\n";
      11: s = ">";
      default: s = string'(byte'($urandom_range(1, 255)));
    endcase
    return s;
  endfunction

  task automatic test_random(int n_bytes, int tx_pct, int rx_pct);
    int    sent;
    string s;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    sent = 0;
    while (sent < n_bytes) begin
      s = random_fragment();
      sent += s.len() + 1;
      send_text(s);
      send_item(KIND_BYTE, $urandom_range(3) == 0 ? "\t" : " ");
    end
  endtask

  task automatic test_directed();
    tx_idle = 0;
    rx_idle = 0;
    send_text("(){},.-+;*/ ! = < > != == <= >= ");
    send_text("and returning _A9 12.5 3.x // skip\n\"ab\ncd\" @ ");
    send_text("7./");
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle = 0;
    rx_hold = 60;
    send_text("a.b.c.1.x/x!x=x<x>x(;)1.(1.)");
    drain();
  endtask

  task automatic test_end();
    send_text("\"open string\200\377");
    send_item(KIND_END, "z");
    // anything after the end is ignored
    send_item(KIND_BYTE, 8'd0);
    send_item(KIND_BYTE, "a");
    send_item(KIND_END, 8'h00);
  endtask

  // receiver ready
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // result checker
  always @(negedge clk) begin
    token_t got;
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ttype = out_tdata[5:0];
      got.err   = out_tdata[7:6];
      got.start = out_tdata[31:8];
      got.len   = out_tdata[55:32];
      got.line  = out_tdata[75:56];
      got.last  = out_tlast;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        if (got != want) begin
          $display("%0t: token mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    rx_hold = 0;
    rx_idle = 0;
    tx_idle = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    mode = M_IDLE;
    tok_start = '0;
    pos = '0;
    lines = 20'd1;
    prefix = '0;
    eof_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_random(45, 29, 80);
    test_random(45, 80, 29);
    test_random(45, 0, 0);
    test_directed();
    test_backpressure();
    test_end();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
